/* src/lsmp_pkg.sv */
package lsmp_pkg;

  localparam int unsigned RANGE_BITS       = 14;
  localparam int unsigned SAMPLE_BITS      = 12;
  localparam int unsigned SECTOR_BITS      = 7;
  localparam int unsigned INDEX_BITS       = 6;
  localparam int unsigned CM_BITS          = 11;
  localparam int unsigned MAX_SECTORS      = 64;
  localparam int unsigned MAX_SCAN_SAMPLES = 4096;
  localparam int unsigned CFG_DATA_BITS    = 14;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned QPTR_BITS        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS        = $clog2(QUEUE_DEPTH + 1);

  // floor(x / 10) == (x * 52429) >> 19 for every x below 81920
  localparam logic [15:0] CM_RECIP = 16'd52429;
  localparam int unsigned CM_SHIFT = 19;

  localparam logic [RANGE_BITS-1:0]  RANGE_ALL_ONES = '1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_LIMIT   = SAMPLE_BITS'(MAX_SCAN_SAMPLES - 1);

  typedef enum logic [1:0] {
    CFG_REGION_START  = 2'd0,
    CFG_SECTOR_WIDTH  = 2'd1,
    CFG_SECTOR_COUNT  = 2'd2,
    CFG_NEAR_THRESH   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] region_start;
    logic [SAMPLE_BITS-1:0] sector_width;
    logic [SECTOR_BITS-1:0] sector_count;
    logic [RANGE_BITS-1:0]  near_threshold_mm;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_counter;
    logic [RANGE_BITS-1:0]  previous_patched;
    logic                   previous_present;
    logic [RANGE_BITS-1:0]  sector_running_min;
    logic [SAMPLE_BITS-1:0] within_sector_count;
    logic [SECTOR_BITS-1:0] current_sector;
    logic [RANGE_BITS-1:0]  scan_running_min;
  } scan_t;

  localparam scan_t SCAN_CLEAR = '{
    sample_counter:      '0,
    previous_patched:    '0,
    previous_present:    1'b0,
    sector_running_min:  RANGE_ALL_ONES,
    within_sector_count: '0,
    current_sector:      '0,
    scan_running_min:    RANGE_ALL_ONES
  };

  typedef struct packed {
    logic [INDEX_BITS-1:0] sector_index;
    logic [RANGE_BITS-1:0] sector_min_mm;
    logic                  near_obstacle;
    logic                  last_sector;
  } result_t;

  typedef struct packed {
    scan_t   st;
    logic    vld;
    result_t res;
  } pool_ret_t;

  // results of one accepted sample, packed from slot zero
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } push_t;

  function automatic pool_ret_t pool_sample(scan_t s, cfg_t c, logic [RANGE_BITS-1:0] p);
    pool_ret_t              r;
    logic [SECTOR_BITS-1:0] cnt;
    logic [SAMPLE_BITS:0]   wnext;
    logic [RANGE_BITS-1:0]  m;
    logic [RANGE_BITS-1:0]  smin;
    logic                   last;
    r     = '0;
    r.st  = s;
    cnt   = (c.sector_count > SECTOR_BITS'(MAX_SECTORS)) ? SECTOR_BITS'(MAX_SECTORS)
                                                          : c.sector_count;
    wnext = {1'b0, s.within_sector_count} + (SAMPLE_BITS+1)'(1);
    m     = (p < s.sector_running_min) ? p : s.sector_running_min;
    smin  = (m < s.scan_running_min) ? m : s.scan_running_min;
    last  = ((s.current_sector + SECTOR_BITS'(1)) == cnt);
    if (s.sample_counter != SAMPLE_LIMIT) begin
      r.st.sample_counter = s.sample_counter + SAMPLE_BITS'(1);
    end
    r.st.previous_patched = p;
    r.st.previous_present = 1'b1;
    if ((s.sample_counter >= c.region_start) && (s.current_sector < cnt)) begin
      if (wnext >= {1'b0, c.sector_width}) begin
        r.vld                     = 1'b1;
        r.res.sector_index        = s.current_sector[INDEX_BITS-1:0];
        r.res.sector_min_mm       = m;
        r.res.near_obstacle       = last && (smin <= c.near_threshold_mm);
        r.res.last_sector         = last;
        r.st.scan_running_min     = smin;
        r.st.sector_running_min   = RANGE_ALL_ONES;
        r.st.within_sector_count  = '0;
        r.st.current_sector       = s.current_sector + SECTOR_BITS'(1);
      end else begin
        r.st.sector_running_min   = m;
        r.st.within_sector_count  = wnext[SAMPLE_BITS-1:0];
      end
    end
    return r;
  endfunction

endpackage

/* src/lsmp_if.sv */
interface lsmp_sample_if;
  import lsmp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [RANGE_BITS-1:0] range_mm;
  logic                  no_return;
  logic                  first_sample;
  logic                  last_sample;

  modport source (output valid, range_mm, no_return, first_sample, last_sample,
                  input ready);
  modport sink   (input valid, range_mm, no_return, first_sample, last_sample,
                  output ready);
endinterface

interface lsmp_sector_if;
  import lsmp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] sector_index;
  logic [RANGE_BITS-1:0] sector_min_mm;
  logic [CM_BITS-1:0]    sector_min_cm;
  logic                  near_obstacle;
  logic                  last_sector;

  modport source (output valid, sector_index, sector_min_mm, sector_min_cm,
                  near_obstacle, last_sector, input ready);
  modport sink   (input valid, sector_index, sector_min_mm, sector_min_cm,
                  near_obstacle, last_sector, output ready);
endinterface

/* src/lsmp_core.sv */
module lsmp_core
  import lsmp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  accept_i,
  input  logic [RANGE_BITS-1:0] range_mm_i,
  input  logic                  no_return_i,
  input  logic                  first_sample_i,
  input  logic                  last_sample_i,
  output push_t                 push_o
);

  scan_t                 scan_q, scan_d;
  logic [RANGE_BITS-1:0] held_sample_q, held_sample_d;
  logic                  held_no_return_q, held_no_return_d;
  logic                  held_valid_q, held_valid_d;

  scan_t                 st0;
  logic                  hv;
  logic [RANGE_BITS:0]   avg_sum;
  logic [RANGE_BITS-1:0] p_held;
  logic [RANGE_BITS-1:0] p_cur;
  pool_ret_t             ra, rb;
  scan_t                 st1;

  always_comb begin
    st0     = first_sample_i ? SCAN_CLEAR : scan_q;
    hv      = held_valid_q && !first_sample_i;
    avg_sum = {1'b0, st0.previous_patched} + {1'b0, range_mm_i};
    if (held_no_return_q) begin
      p_held = (st0.previous_present && !no_return_i) ? avg_sum[RANGE_BITS:1] : '0;
    end else begin
      p_held = held_sample_q;
    end
    p_cur = no_return_i ? '0 : range_mm_i;

    // held sample first, then the current one when the scan ends here
    ra  = pool_sample(st0, cfg_i, p_held);
    st1 = hv ? ra.st : st0;
    rb  = pool_sample(st1, cfg_i, p_cur);

    push_o = '0;
    if (hv && ra.vld) begin
      push_o.res0 = ra.res;
      push_o.res1 = rb.res;
      push_o.num  = (last_sample_i && rb.vld) ? 2'd2 : 2'd1;
    end else begin
      push_o.res0 = rb.res;
      push_o.res1 = rb.res;
      push_o.num  = (last_sample_i && rb.vld) ? 2'd1 : 2'd0;
    end
    if (!accept_i) begin
      push_o.num = 2'd0;
    end

    scan_d           = scan_q;
    held_sample_d    = held_sample_q;
    held_no_return_d = held_no_return_q;
    held_valid_d     = held_valid_q;
    if (accept_i) begin
      if (last_sample_i) begin
        scan_d       = SCAN_CLEAR;
        held_valid_d = 1'b0;
      end else begin
        scan_d           = st1;
        held_sample_d    = range_mm_i;
        held_no_return_d = no_return_i;
        held_valid_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q           <= SCAN_CLEAR;
      held_sample_q    <= '0;
      held_no_return_q <= 1'b0;
      held_valid_q     <= 1'b0;
    end else begin
      scan_q           <= scan_d;
      held_sample_q    <= held_sample_d;
      held_no_return_q <= held_no_return_d;
      held_valid_q     <= held_valid_d;
    end
  end

endmodule

/* src/lsmp_result_queue.sv */
module lsmp_result_queue
  import lsmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  push_t         push_i,
  output logic          room_o,
  lsmp_sector_if.source sector_o
);

  result_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]  count_q, count_d;
  logic                  pop;
  result_t               head;
  logic [RANGE_BITS:0]   cm_num;
  logic [RANGE_BITS+16:0] cm_prod;

  assign room_o = (count_q <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign pop    = sector_o.valid && sector_o.ready;
  assign head   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_BITS'(push_i.num);
    rd_ptr_d = rd_ptr_q + QPTR_BITS'(pop);
    count_d  = count_q + QCNT_BITS'(push_i.num) - QCNT_BITS'(pop);
  end

  // cm rounding by reciprocal multiply
  always_comb begin
    cm_num  = {1'b0, head.sector_min_mm} + (RANGE_BITS+1)'(5);
    cm_prod = cm_num * CM_RECIP;
  end

  assign sector_o.valid         = (count_q != '0);
  assign sector_o.sector_index  = head.sector_index;
  assign sector_o.sector_min_mm = head.sector_min_mm;
  assign sector_o.sector_min_cm = cm_prod[CM_SHIFT +: CM_BITS];
  assign sector_o.near_obstacle = head.near_obstacle;
  assign sector_o.last_sector   = head.last_sector;

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_q + QPTR_BITS'(1)] <= push_i.res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* src/lidar_sector_min_pool_unit.sv */
// lidar sector minimum pooling
// sample_i takes one range sample per transaction in scan order, with a
// no-return flag and first/last scan markers; sector_o gives one transaction
// per finished sector: sector index, minimum in mm and in cm, last-sector
// flag and, on the last sector, the near-obstacle flag
// a sample with no return is patched from its predecessor and its successor,
// so each sample is pooled when the next one arrives (or at once on the last
// sample of a scan)
// throughput: one sample per cycle while sample_i.ready is high; the sector
// results of a sample are written into the result queue when it is pooled
// a scan-ending sample can finish two sectors; both enter a four-entry result
// queue and leave one per cycle while sector_o.ready is high
// when the receiver stalls the queue fills; sample_i.ready drops while fewer
// than two entries are free, so no result is ever dropped
// reset clears scan state and the queue and loads default configuration:
// region start 90, sector width 18, sector count 10, threshold 120 mm
// configuration writes go through cfg_we_i / cfg_idx_i / cfg_wdata_i and
// must only happen while the block is idle
module lidar_sector_min_pool_unit
  import lsmp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  lsmp_sample_if.sink              sample_i,
  lsmp_sector_if.source            sector_o
);

  cfg_t  cfg_q, cfg_d;
  logic  room;
  logic  accept;
  push_t push;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_REGION_START: cfg_d.region_start      = cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_SECTOR_WIDTH: cfg_d.sector_width      = cfg_wdata_i[SAMPLE_BITS-1:0];
        CFG_SECTOR_COUNT: cfg_d.sector_count      = cfg_wdata_i[SECTOR_BITS-1:0];
        CFG_NEAR_THRESH:  cfg_d.near_threshold_mm = cfg_wdata_i[RANGE_BITS-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_start      <= SAMPLE_BITS'(90);
      cfg_q.sector_width      <= SAMPLE_BITS'(18);
      cfg_q.sector_count      <= SECTOR_BITS'(10);
      cfg_q.near_threshold_mm <= RANGE_BITS'(120);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // accept while the queue can take two results
  assign sample_i.ready = room;
  assign accept         = sample_i.valid && room;

  lsmp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .range_mm_i     (sample_i.range_mm),
    .no_return_i    (sample_i.no_return),
    .first_sample_i (sample_i.first_sample),
    .last_sample_i  (sample_i.last_sample),
    .push_o         (push)
  );

  lsmp_result_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .room_o   (room),
    .sector_o (sector_o)
  );

endmodule
